@@ rtl/core/ctp_pkg.sv @@
// ----------------------------------------------------------------------------
// ctp_pkg
// shared constants and types of the command tag pool
// ----------------------------------------------------------------------------
package ctp_pkg;

   // pool geometry
   localparam int NUM_TAGS = 2048;
   localparam int TAG_W    = 11;                      // width of a tag field
   localparam int PTR_W    = $clog2(NUM_TAGS);        // ring slot index
   localparam int CNT_W    = $clog2(NUM_TAGS + 1);    // free count, holds NUM_TAGS

   // stream payload widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

@@ rtl/core/command_tag_pool_core.sv @@
// ----------------------------------------------------------------------------
// command_tag_pool_core
// command tag pool: free tag ring plus busy bitmap, both in block memory
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction per command, req_tuser carries the op
//   (allocate, free, query), req_tdata the tag to free or query
//   rsp channel: exactly one transaction per request, carrying the
//   allocated or echoed tag, its busy bit after the op, and a status
//   (ok, pool empty on allocate, pool full on free)
// sequence
//   on accept the ring slot and the busy bit are read synchronously into
//   registers; in ST_EXEC, once the output register is free, both memories
//   are updated and the response register loaded; no new request is taken
//   until the block is back in ST_IDLE
// reset
//   after reset a clearing pass writes tag i into ring slot i for every
//   slot and clears every busy bit; req_tready stays low meanwhile
// stall
//   a waiting response sits in the output register; the next request is
//   still accepted and its update waits until the register is free
// ----------------------------------------------------------------------------
module command_tag_pool_core
   import ctp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,    // [10:0] tag_in, rest zero
   input  logic [REQ_USER_W-1:0] req_tuser,    // [1:0] op
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // [10:0] tag_out, [11] busy_res, rest zero
   output logic [RSP_USER_W-1:0] rsp_tuser     // [1:0] status
);

   // memories
   logic [TAG_W-1:0] ring_mem [NUM_TAGS];
   logic             busy_mem [NUM_TAGS];

   // control state
   state_type        state_ff, state_in;
   logic [PTR_W-1:0] clr_ff, clr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   op_type           op_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [TAG_W-1:0] ring_rd_ff;
   logic             busy_rd_ff;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic             rsp_busy_ff, rsp_busy_in;
   status_type       rsp_status_ff, rsp_status_in;

   // memory ports
   logic             ring_we;
   logic [PTR_W-1:0] ring_waddr;
   logic [TAG_W-1:0] ring_wdata;
   logic             busy_we;
   logic [PTR_W-1:0] busy_waddr;
   logic             busy_wdata;

   logic             accept;
   logic             out_free;
   logic             exec_go;
   logic             clr_last;
   logic             tag_in_range;
   logic             ring_tag_in_range;
   logic [TAG_W-1:0] req_tag;

   assign req_tag  = req_tdata[TAG_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;
   assign exec_go  = (state_ff == ST_EXEC) && out_free;
   assign clr_last = (clr_ff == PTR_W'(NUM_TAGS - 1));

   // tags beyond the pool only matter when the pool is smaller than the field
   assign tag_in_range      = (32'(tag_ff) < NUM_TAGS);
   assign ring_tag_in_range = (32'(ring_rd_ff) < NUM_TAGS);

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      advance = (p == PTR_W'(NUM_TAGS - 1)) ? '0 : p + 1'b1;
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs of the sequencer: memory writes, pointer and response updates
   always_comb begin
      req_tready    = (state_ff == ST_IDLE);
      clr_in        = clr_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      ring_we       = 1'b0;
      ring_waddr    = wr_ptr_ff;
      ring_wdata    = tag_ff;
      busy_we       = 1'b0;
      busy_waddr    = tag_ff[PTR_W-1:0];
      busy_wdata    = 1'b0;
      rsp_tag_in    = tag_ff;
      rsp_busy_in   = 1'b0;
      rsp_status_in = STS_OK;

      unique case (op_ff)
         OP_ALLOC: begin
            if (count_ff == '0) begin
               rsp_tag_in    = '0;
               rsp_status_in = STS_EMPTY;
            end else begin
               rsp_tag_in = ring_rd_ff;
               rsp_busy_in = ring_tag_in_range;
               if (exec_go) begin
                  rd_ptr_in  = advance(rd_ptr_ff);
                  count_in   = count_ff - 1'b1;
                  busy_we    = ring_tag_in_range;
                  busy_waddr = ring_rd_ff[PTR_W-1:0];
                  busy_wdata = 1'b1;
               end
            end
         end
         OP_FREE: begin
            if (tag_in_range) begin
               if (count_ff == CNT_W'(NUM_TAGS)) begin
                  rsp_busy_in   = busy_rd_ff;
                  rsp_status_in = STS_FULL;
               end else if (exec_go) begin
                  ring_we   = 1'b1;
                  busy_we   = 1'b1;
                  wr_ptr_in = advance(wr_ptr_ff);
                  count_in  = count_ff + 1'b1;
               end
            end
         end
         default: begin
            // query, and the unused op code behaves as a query
            rsp_busy_in = tag_in_range && busy_rd_ff;
         end
      endcase

      // clearing pass owns both write ports
      if (state_ff == ST_CLEAR) begin
         ring_we    = 1'b1;
         ring_waddr = clr_ff;
         ring_wdata = TAG_W'(clr_ff);
         busy_we    = 1'b1;
         busy_waddr = clr_ff;
         busy_wdata = 1'b0;
         clr_in     = clr_ff + 1'b1;
      end

      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= CNT_W'(NUM_TAGS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_tuser[1:0]);
         tag_ff <= req_tag;
      end
      if (exec_go) begin
         rsp_tag_ff    <= rsp_tag_in;
         rsp_busy_ff   <= rsp_busy_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // free tag ring: read the head slot on accept, hold the data until exec
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      if (accept) begin
         ring_rd_ff <= ring_mem[rd_ptr_ff];
      end
   end

   // busy bitmap: read the requested tag on accept
   always_ff @(posedge clock) begin
      if (busy_we) begin
         busy_mem[busy_waddr] <= busy_wdata;
      end
      if (accept) begin
         busy_rd_ff <= busy_mem[req_tag[PTR_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - TAG_W - 1){1'b0}}, rsp_busy_ff, rsp_tag_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ tb/command_tag_pool_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_tag_pool_checker
// watches the request and response streams, keeps its own copy of the free
// tag ring and busy map, and checks each response against it field by field
// ----------------------------------------------------------------------------
module command_tag_pool_checker
   import ctp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,    // [10:0] tag_in, rest zero
   input  logic [REQ_USER_W-1:0] req_tuser,    // [1:0] op
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,    // [10:0] tag_out, [11] busy_res, rest zero
   input  logic [RSP_USER_W-1:0] rsp_tuser,    // [1:0] status
   output int                    error_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             busy;
      status_type       status;
   } tag_answer_type;

   logic [TAG_W-1:0] free_tags [NUM_TAGS];
   logic             tag_busy  [NUM_TAGS];
   logic [PTR_W-1:0] pop_slot;
   logic [PTR_W-1:0] push_slot;
   logic [CNT_W-1:0] free_total;
   tag_answer_type   tag_answers [$];

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
      return (int'(slot) == NUM_TAGS - 1) ? '0 : slot + 1'b1;
   endfunction

   // applies one transaction to the pool copy and returns its response
   // every 11-bit tag is below NUM_TAGS, so no range test is needed
   function automatic tag_answer_type serve_tag_op(input logic [1:0]       op,
                                                   input logic [TAG_W-1:0] tag);
      tag_answer_type answer;
      answer.tag    = tag;
      answer.busy   = 1'b0;
      answer.status = STS_OK;
      if (op == OP_ALLOC) begin
         if (free_total == 0) begin
            answer.tag    = '0;
            answer.status = STS_EMPTY;
         end else begin
            answer.tag           = free_tags[pop_slot];
            pop_slot             = next_slot(pop_slot);
            free_total           = free_total - 1'b1;
            tag_busy[answer.tag] = 1'b1;
            answer.busy          = 1'b1;
         end
      end else if (op == OP_FREE) begin
         if (free_total == NUM_TAGS) begin
            answer.busy   = tag_busy[tag];
            answer.status = STS_FULL;
         end else begin
            // pushed even when the tag was not busy
            free_tags[push_slot] = tag;
            push_slot            = next_slot(push_slot);
            free_total           = free_total + 1'b1;
            tag_busy[tag]        = 1'b0;
         end
      end else begin
         // query, and the spare op code behaves the same
         answer.busy = tag_busy[tag];
      end
      return answer;
   endfunction

   function automatic void compare_field(input string field, input logic [15:0] wanted,
                                         input logic [15:0] seen);
      if (seen !== wanted) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, wanted, seen);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      tag_answer_type awaited;
      if (reset) begin
         for (int i = 0; i < NUM_TAGS; i++) begin
            free_tags[i] = TAG_W'(i);
            tag_busy[i]  = 1'b0;
         end
         pop_slot   = '0;
         push_slot  = '0;
         free_total = CNT_W'(NUM_TAGS);
         tag_answers.delete();
      end else begin
         // a response never belongs to a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (tag_answers.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual %h/%0d",
                        $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               awaited = tag_answers.pop_front();
               compare_field("tag_out", 16'(awaited.tag), 16'(rsp_tdata[TAG_W-1:0]));
               compare_field("busy_res", 16'(awaited.busy), 16'(rsp_tdata[TAG_W]));
               compare_field("status", 16'(awaited.status), 16'(rsp_tuser));
               compare_field("tdata padding", '0, 16'(rsp_tdata[RSP_DATA_W-1:TAG_W+1]));
            end
         end
         if (req_tvalid && req_tready)
            tag_answers.push_back(serve_tag_op(req_tuser, req_tdata[TAG_W-1:0]));
      end
      pending_count <= tag_answers.size();
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives allocate, free and query transactions into the command tag pool,
// checks refusals on the full pool and ring order on allocate, then runs a
// random mix while both sides stall at random; a checker module predicts
// every response
// ----------------------------------------------------------------------------
module testbench;
   import ctp_pkg::*;

   // spare op code, acts as a query
   localparam logic [REQ_USER_W-1:0] OP_SPARE = 2'd3;

   localparam int RANDOM_ITEMS = 600;
   localparam int IDLE_LIMIT   = 10000;   // covers the clearing pass several times
   localparam int LONG_HOLD    = 150;     // receiver hold-off that fills the block
   localparam int SETTLE       = 20;      // cycles after the last response

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [10:0] tag_in, rest zero
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // [1:0] op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [10:0] tag_out, [11] busy_res, rest zero
   logic [RSP_USER_W-1:0] rsp_tuser;         // [1:0] status
   int                    error_count;
   int                    pending_count;

   // stimulus bookkeeping, touched only by the stimulus process
   logic [REQ_USER_W-1:0] ops_in_flight [$];   // op of each transaction still unanswered
   logic [TAG_W-1:0]      held_tags [$];       // tags seen allocated and not yet freed
   bit                    tag_held [NUM_TAGS];
   bit                    sender_calm;

   // receiver state
   bit                    hold_off_request = 1'b0;
   bit                    hold_taken;
   bit                    stall_free;
   int                    stall_left;
   int                    mode_cycles;

   int                    idle_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   command_tag_pool_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   command_tag_pool_checker tag_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // one clock edge for the stimulus process; notes what moved at that edge
   // so that the choice of tags to free stays in this one process
   task automatic tick();
      logic [REQ_USER_W-1:0] op_done;
      @(posedge clock);
      if (rsp_tvalid && rsp_tready && ops_in_flight.size() > 0) begin
         op_done = ops_in_flight.pop_front();
         if (op_done == OP_ALLOC && rsp_tuser == STS_OK && !tag_held[rsp_tdata[TAG_W-1:0]]) begin
            tag_held[rsp_tdata[TAG_W-1:0]] = 1'b1;
            held_tags.push_back(rsp_tdata[TAG_W-1:0]);
         end
      end
      if (req_tvalid && req_tready)
         ops_in_flight.push_back(req_tuser);
   endtask

   // sender gaps: mostly none or short, a few long, none in calm stretches
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_calm || roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // offers one transaction and returns at the edge where it is taken
   task automatic send_request(input logic [REQ_USER_W-1:0] op, input logic [TAG_W-1:0] tag);
      int gap;
      int slot;
      gap = pick_gap();
      if (op == OP_FREE && tag_held[tag]) begin
         tag_held[tag] = 1'b0;
         for (slot = 0; slot < held_tags.size(); slot++)
            if (held_tags[slot] == tag)
               break;
         held_tags.delete(slot);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) tick();
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'(tag);
      do tick(); while (!req_tready);
   endtask

   // drops valid and waits for every response to come back
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      do tick(); while (ops_in_flight.size() > 0);
   endtask

   function automatic logic [TAG_W-1:0] any_held_tag();
      return held_tags[$urandom_range(0, held_tags.size() - 1)];
   endfunction

   initial begin
      int roll;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // pool is full after the clearing pass, so frees are refused
      send_request(OP_FREE, '0);
      send_request(OP_FREE, '1);
      send_request(OP_QUERY, '0);
      send_request(OP_QUERY, '1);
      send_request(OP_SPARE, 11'd5);
      // allocations come out in ring order, tag_in is ignored
      send_request(OP_ALLOC, '1);
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, 11'h2aa);
      send_request(OP_QUERY, 11'd1);
      send_request(OP_SPARE, 11'd2);
      // free, then free the same tag again while not busy
      send_request(OP_FREE, 11'd1);
      send_request(OP_FREE, 11'd1);
      send_request(OP_QUERY, 11'd1);
      // free of a tag that was never handed out
      send_request(OP_FREE, '1);
      send_request(OP_QUERY, '0);
      send_request(OP_FREE, '0);
      send_request(OP_ALLOC, 11'h555);
      send_request(OP_QUERY, 11'd3);
      wait_until_idle();

      // ---- random mix of allocates, frees and queries, mostly of held tags, plus some noise ----
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
         // one long receiver hold-off while the sender keeps offering
         if (n == RANDOM_ITEMS / 3)
            hold_off_request <= 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            send_request(OP_ALLOC, TAG_W'($urandom));
         end else if (roll < 75) begin
            if (roll < 70 && held_tags.size() > 0)
               send_request(OP_FREE, any_held_tag());
            else
               send_request(OP_FREE, TAG_W'($urandom));
         end else if (roll < 95) begin
            if (roll < 85 && held_tags.size() > 0)
               send_request(OP_QUERY, any_held_tag());
            else
               send_request(OP_QUERY, TAG_W'($urandom));
         end else begin
            send_request(OP_SPARE, TAG_W'($urandom));
         end
      end

      // ---- wind down ----
      wait_until_idle();
      repeat (SETTLE) tick();
      if (error_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stalls in some stretches, none in others, plus one
   // long hold-off on request
   always @(posedge clock) begin
      int roll;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_cycles == 0) begin
            stall_free  = ($urandom_range(0, 3) == 0);
            mode_cycles = 300;
         end
         mode_cycles--;
         if (hold_off_request && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            roll = $urandom_range(0, 99);
            if (!stall_free && roll >= 70)
               stall_left = (roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

@@ sim.f @@
rtl/core/ctp_pkg.sv
rtl/core/command_tag_pool_core.sv
tb/command_tag_pool_checker.sv
tb/testbench.sv
